>>> rtl/mqmp_pkg.sv
// shared types and constants for the multi-queue move and peek block
package mqmp_pkg;

   localparam int REQ_TDATA_W = 24;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 16;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int CFG_W       = 5;
   localparam int CELL_W      = 10;

   localparam logic [CELL_W-1:0] CELL_NONE = 10'h3FF;

   localparam logic CSR_IDX_NUM_ROWS = 1'b0;
   localparam logic CSR_IDX_ROW_LEN  = 1'b1;

   typedef enum logic [1:0] {
      ACT_INIT  = 2'd0,
      ACT_MOVE  = 2'd1,
      ACT_QUERY = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_M_RS,
      ST_M_RD,
      ST_M_LK,
      ST_M_WS,
      ST_M_WD,
      ST_Q_RS,
      ST_Q_CK,
      ST_Q_DEC,
      ST_Q_WALK,
      ST_Q_CAP,
      ST_Q_OUT
   } state_type;

   typedef struct packed {
      logic item_load;
      logic init_step;
      logic row_rd_src;
      logic row_rd_dst;
      logic cap_src;
      logic cap_dst;
      logic link_rd_head;
      logic mv_wr_src;
      logic mv_wr_dst;
      logic q_start;
      logic q_oor;
      logic walk_rd;
      logic walk_cap;
      logic rsp_load;
   } mqmp_cmd_type;

   typedef struct packed {
      action_type req_action;
      logic       init_last;
      logic       src_ok;
      logic       dst_ok;
      logic       src_empty;
      logic       pos_ok;
      logic       walk_done;
      logic       rsp_free;
   } mqmp_status_type;

endpackage

>>> rtl/mqmp_ctrl.sv
// sequencer for init, move and query items
module mqmp_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  mqmp_pkg::mqmp_status_type sts,
   output mqmp_pkg::mqmp_cmd_type    cmd
);
   import mqmp_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               unique case (sts.req_action)
                  ACT_INIT:  state_in = ST_INIT;
                  ACT_MOVE:  state_in = ST_M_RS;
                  ACT_QUERY: state_in = ST_Q_RS;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_INIT:  if (sts.init_last) state_in = ST_IDLE;
         ST_M_RS:  state_in = ST_M_RD;
         ST_M_RD:  state_in = ST_M_LK;
         ST_M_LK: begin
            if (sts.src_ok && sts.dst_ok && !sts.src_empty) state_in = ST_M_WS;
            else state_in = ST_IDLE;
         end
         ST_M_WS:  state_in = ST_M_WD;
         ST_M_WD:  state_in = ST_IDLE;
         ST_Q_RS:  state_in = ST_Q_CK;
         ST_Q_CK:  state_in = ST_Q_DEC;
         ST_Q_DEC: begin
            if (sts.src_ok && sts.pos_ok) state_in = ST_Q_WALK;
            else state_in = ST_Q_OUT;
         end
         ST_Q_WALK: begin
            if (sts.walk_done) state_in = ST_Q_OUT;
            else state_in = ST_Q_CAP;
         end
         ST_Q_CAP: state_in = ST_Q_WALK;
         ST_Q_OUT: if (sts.rsp_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready    = 1'b1;
            cmd.item_load = req_tvalid;
         end
         ST_INIT:  cmd.init_step = 1'b1;
         ST_M_RS:  cmd.row_rd_src = 1'b1;
         ST_M_RD: begin
            cmd.cap_src    = 1'b1;
            cmd.row_rd_dst = 1'b1;
         end
         ST_M_LK: begin
            cmd.cap_dst      = 1'b1;
            cmd.link_rd_head = 1'b1;
         end
         ST_M_WS:  cmd.mv_wr_src = 1'b1;
         ST_M_WD:  cmd.mv_wr_dst = 1'b1;
         ST_Q_RS:  cmd.row_rd_src = 1'b1;
         ST_Q_CK:  cmd.cap_src = 1'b1;
         ST_Q_DEC: begin
            if (sts.src_ok && sts.pos_ok) cmd.q_start = 1'b1;
            else cmd.q_oor = 1'b1;
         end
         ST_Q_WALK: cmd.walk_rd = !sts.walk_done;
         ST_Q_CAP:  cmd.walk_cap = 1'b1;
         ST_Q_OUT:  cmd.rsp_load = sts.rsp_free;
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

>>> rtl/mqmp_dp.sv
// datapath: registers, row table, link memory, result register
module mqmp_dp #(
   parameter int MAX_ROWS    = 16,
   parameter int MAX_ROW_LEN = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [mqmp_pkg::REQ_TUSER_W-1:0]      req_tuser,
   input  logic [mqmp_pkg::REQ_TDATA_W-1:0]      req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [mqmp_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [mqmp_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [mqmp_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [mqmp_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready,
   input  mqmp_pkg::mqmp_cmd_type                cmd,
   output mqmp_pkg::mqmp_status_type             sts
);
   import mqmp_pkg::*;

   localparam int POOL = MAX_ROWS * MAX_ROW_LEN;
   localparam int PW   = (POOL > 1) ? $clog2(POOL) : 1;
   localparam int CW   = $clog2(POOL + 1);
   localparam int RW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int RWD  = 2 * PW + CW;
   localparam int CMPW = (CW > 8) ? CW : 8;

   // configuration registers
   logic [CFG_W-1:0] num_rows_ff, row_len_ff;
   logic             csr_wr;

   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff <= CFG_W'(1);
         row_len_ff  <= CFG_W'(1);
      end else if (csr_wr) begin
         if (csr_paddr[2] == CSR_IDX_NUM_ROWS) num_rows_ff <= csr_pwdata[CFG_W-1:0];
         else row_len_ff <= csr_pwdata[CFG_W-1:0];
      end
   end

   always_comb begin
      if (csr_paddr[2] == CSR_IDX_NUM_ROWS) csr_prdata = CSR_DATA_W'(num_rows_ff);
      else csr_prdata = CSR_DATA_W'(row_len_ff);
   end

   // saturated row count and row length
   logic [7:0] num8, len8r, rows8, len8;
   assign num8  = 8'(num_rows_ff);
   assign len8r = 8'(row_len_ff);
   assign rows8 = (num8 == 8'd0) ? 8'd1 : ((num8 > 8'(MAX_ROWS)) ? 8'(MAX_ROWS) : num8);
   assign len8  = (len8r == 8'd0) ? 8'd1 :
                  ((len8r > 8'(MAX_ROW_LEN)) ? 8'(MAX_ROW_LEN) : len8r);

   // item fields
   logic [7:0] src_ff, dst_ff, pos_ff;
   always_ff @(posedge clock) begin
      if (cmd.item_load) begin
         src_ff <= req_tdata[7:0];
         dst_ff <= req_tdata[15:8];
         pos_ff <= req_tdata[23:16];
      end
   end

   // init sweep counter
   logic [PW-1:0] init_cnt_ff;
   always_ff @(posedge clock) begin
      if (cmd.item_load) init_cnt_ff <= '0;
      else if (cmd.init_step) init_cnt_ff <= init_cnt_ff + PW'(1);
   end

   logic            init_row, init_used;
   logic [PW+7:0]   ihead_w, itail_w;
   logic [CW-1:0]   icount;
   assign init_row  = {1'b0, init_cnt_ff} < (PW+1)'(MAX_ROWS);
   assign init_used = (PW+8)'(init_cnt_ff) < (PW+8)'(rows8);
   assign ihead_w   = (PW+8)'(init_cnt_ff) * (PW+8)'(len8);
   assign itail_w   = ihead_w + (PW+8)'(len8) - (PW+8)'(1);
   assign icount    = init_used ? CW'(len8) : '0;

   // row table and link memory
   logic [RWD-1:0] row_mem [MAX_ROWS];
   logic [PW-1:0]  link_mem [POOL];
   logic           row_vld_ff [MAX_ROWS];
   logic [RWD-1:0] row_rdata_ff;
   logic           row_vrd_ff;
   logic [PW-1:0]  link_rdata_ff;

   logic [PW-1:0] s_head_ff, s_tail_ff, d_head_ff, d_tail_ff, elem_ff;
   logic [CW-1:0] s_cnt_ff, d_cnt_ff;
   logic [7:0]    k_ff;
   logic          oor_ff;

   logic           same_row;
   logic [PW-1:0]  d_head_eff, d_tail_eff, new_head;
   logic [CW-1:0]  d_cnt_eff;
   assign same_row   = (src_ff == dst_ff);
   assign d_head_eff = same_row ? link_rdata_ff : d_head_ff;
   assign d_tail_eff = same_row ? s_tail_ff : d_tail_ff;
   assign d_cnt_eff  = same_row ? (s_cnt_ff - CW'(1)) : d_cnt_ff;
   assign new_head   = (d_cnt_eff == '0) ? s_head_ff : d_head_eff;

   logic           row_we;
   logic [RW-1:0]  row_waddr, row_raddr;
   logic [RWD-1:0] row_wdata;
   logic           row_re;

   always_comb begin
      row_we    = 1'b0;
      row_waddr = init_cnt_ff[RW-1:0];
      row_wdata = {PW'(ihead_w), PW'(itail_w), icount};
      if (cmd.init_step) begin
         row_we = init_row;
      end else if (cmd.mv_wr_src) begin
         row_we    = 1'b1;
         row_waddr = src_ff[RW-1:0];
         row_wdata = {link_rdata_ff, s_tail_ff, s_cnt_ff - CW'(1)};
      end else if (cmd.mv_wr_dst) begin
         row_we    = 1'b1;
         row_waddr = dst_ff[RW-1:0];
         row_wdata = {new_head, s_head_ff, d_cnt_eff + CW'(1)};
      end
   end

   assign row_re    = cmd.row_rd_src || cmd.row_rd_dst;
   assign row_raddr = cmd.row_rd_dst ? dst_ff[RW-1:0] : src_ff[RW-1:0];

   always_ff @(posedge clock) begin
      if (row_we) row_mem[row_waddr] <= row_wdata;
      if (row_re) row_rdata_ff <= row_mem[row_raddr];
   end

   // valid bits stand for the cleared counts after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_ROWS; i++) row_vld_ff[i] <= 1'b0;
      end else if (row_we) begin
         row_vld_ff[row_waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (row_re) row_vrd_ff <= row_vld_ff[row_raddr];
   end

   logic          link_we, link_re;
   logic [PW-1:0] link_waddr, link_wdata, link_raddr;

   always_comb begin
      link_we    = 1'b0;
      link_waddr = init_cnt_ff;
      link_wdata = init_cnt_ff + PW'(1);
      if (cmd.init_step) begin
         link_we = 1'b1;
      end else if (cmd.mv_wr_dst) begin
         link_we    = (d_cnt_eff != '0);
         link_waddr = d_tail_eff;
         link_wdata = s_head_ff;
      end
   end

   assign link_re    = cmd.link_rd_head || cmd.walk_rd;
   assign link_raddr = cmd.walk_rd ? elem_ff : s_head_ff;

   always_ff @(posedge clock) begin
      if (link_we) link_mem[link_waddr] <= link_wdata;
      if (link_re) link_rdata_ff <= link_mem[link_raddr];
   end

   // captured row words
   always_ff @(posedge clock) begin
      if (cmd.cap_src) begin
         s_head_ff <= row_rdata_ff[RWD-1 -: PW];
         s_tail_ff <= row_rdata_ff[CW+PW-1 -: PW];
         s_cnt_ff  <= row_vrd_ff ? row_rdata_ff[CW-1:0] : '0;
      end
      if (cmd.cap_dst) begin
         d_head_ff <= row_rdata_ff[RWD-1 -: PW];
         d_tail_ff <= row_rdata_ff[CW+PW-1 -: PW];
         d_cnt_ff  <= row_vrd_ff ? row_rdata_ff[CW-1:0] : '0;
      end
   end

   // list walk
   always_ff @(posedge clock) begin
      if (cmd.q_start) begin
         elem_ff <= s_head_ff;
         k_ff    <= 8'd0;
      end else if (cmd.walk_cap) begin
         elem_ff <= link_rdata_ff;
         k_ff    <= k_ff + 8'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) oor_ff <= 1'b0;
      else if (cmd.q_start) oor_ff <= 1'b0;
      else if (cmd.q_oor) oor_ff <= 1'b1;
   end

   // result register
   logic              rsp_valid_ff;
   logic [CELL_W-1:0] rsp_cell_ff, res_cell;
   logic [PW:0]       elem_val;

   assign elem_val = {1'b0, elem_ff} + (PW+1)'(1);
   assign res_cell = oor_ff ? CELL_NONE : CELL_W'(elem_val);

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.rsp_load) rsp_valid_ff <= 1'b1;
      else if (rsp_tready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) rsp_cell_ff <= res_cell;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_cell_ff);

   // status
   assign sts.req_action = action_type'(req_tuser);
   assign sts.init_last  = (init_cnt_ff == PW'(POOL - 1));
   assign sts.src_ok     = src_ff < rows8;
   assign sts.dst_ok     = dst_ff < rows8;
   assign sts.src_empty  = (s_cnt_ff == '0);
   assign sts.pos_ok     = CMPW'(pos_ff) < CMPW'(s_cnt_ff);
   assign sts.walk_done  = (k_ff == pos_ff);
   assign sts.rsp_free   = !rsp_valid_ff || rsp_tready;

endmodule

>>> rtl/multi_queue_move_and_peek.sv
// top level: row queues sharing one linked element pool
//
//  channel | dir | handshake               | payload
//  req     | in  | req_tvalid/req_tready   | tuser: action; tdata: source_row, dest_row, position
//  rsp     | out | rsp_tvalid/rsp_tready   | rsp_tdata: cell_value
//  csr     | in  | csr_psel/csr_penable    | num_rows @0, row_len @4
//
// one item at a time; req_tready is high only while the sequencer is idle
// init: sweeps the whole element pool, one link memory write per cycle
// move: row table reads, link read, two row table writes; ends after the link read when ignored
// query: position link reads after the row read, none when out of range; the walk alternates reads and captures
// reset clears the sequencer, row valid bits and result register; configuration resets to 1
// a held result stalls only a query that finishes while the result waits
module multi_queue_move_and_peek #(
   parameter int MAX_ROWS    = 16,
   parameter int MAX_ROW_LEN = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [1:0] action
   input  logic [mqmp_pkg::REQ_TUSER_W-1:0]     req_tuser,
   // [7:0] source_row, [15:8] dest_row, [23:16] position
   input  logic [mqmp_pkg::REQ_TDATA_W-1:0]     req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [9:0] cell_value
   output logic [mqmp_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [mqmp_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [mqmp_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [mqmp_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);
   import mqmp_pkg::*;

   mqmp_cmd_type    cmd;
   mqmp_status_type sts;

   mqmp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   mqmp_dp #(
      .MAX_ROWS    (MAX_ROWS),
      .MAX_ROW_LEN (MAX_ROW_LEN)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule

>>> rtl/mqmp_checker.sv
// port checker for the top level, attached by bind
module mqmp_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_tvalid,
   input logic                                 req_tready,
   input logic [mqmp_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic [mqmp_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   input logic                                 csr_psel,
   input logic                                 csr_penable,
   input logic                                 csr_pwrite,
   input logic [mqmp_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input logic [mqmp_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   input logic [mqmp_pkg::CSR_DATA_W-1:0]      csr_prdata,
   input logic                                 csr_pready
);
   import mqmp_pkg::*;

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   // padding above the cell value stays zero
   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_TDATA_W-1:CELL_W] == '0)
      else $error("rsp padding not zero");

   // no result right after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   // configuration readback only uses the register bits
   a_csr_read: assert property (@(posedge clock) disable iff (reset)
      csr_pready && csr_prdata[CSR_DATA_W-1:CFG_W] == '0)
      else $error("csr read data out of range");

endmodule

bind multi_queue_move_and_peek mqmp_checker u_mqmp_checker (.*);
